FILE: rtl/bda_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package bda_pkg;

	localparam int VALUE_W        = 64;
	localparam int CHAR_W         = 6;
	localparam int MAX_DIGITS_DEF = 20;
	localparam int BITCNT_W       = 7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	// configuration register indexes
	localparam logic [1:0] REG_OPERAND_WIDTH = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE   = 2'd1;

	typedef enum logic [1:0] {
		WIDTH_8  = 2'd0,
		WIDTH_16 = 2'd1,
		WIDTH_32 = 2'd2,
		WIDTH_64 = 2'd3
	} width_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// operations requested from the datapath
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift_digit;
	} bda_op_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic [3:0] top_digit;
		logic       overflow;
		logic       negative;
	} bda_status_t;

endpackage

FILE: rtl/binary_to_decimal_ascii.sv
// binary to decimal ascii converter top level
`timescale 1ns / 1ps
//
// Converts one integer operand to its decimal text, most significant
// character first, with a leading '-' for negative operands in signed mode.
// Command channel: value is taken at a clock edge where start is high and
// busy is low; busy stays high until the final character has been issued.
// Results: each character appears on character/last for one cycle, marked
// by strobe; last flags the final character. The receiver cannot stall.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 operand_width,
// 1 signed_mode) and cfg_data; cfg_ready is always high; writes to other
// indexes are dropped. Write only while busy is low.
// Sequence: one shift and add-3 step per operand bit (8, 16, 32 or 64
// bits), a '-' character when the operand is negative, then leading zero
// skip and digit emission, most significant digit first.
// A new item may be started as soon as busy drops.
// Reset: width 64 bits, unsigned, sequencer idle, no strobe.
//
module binary_to_decimal_ascii import bda_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	output logic               strobe,
	output logic [CHAR_W-1:0]  character,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data
);

	width_code_t       width_q;
	logic              signed_q;
	bda_op_t           op;
	bda_status_t       status;
	logic              emit;
	logic [CHAR_W-1:0] emit_char;
	logic              emit_last;
	logic              strobe_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_64;
			signed_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OPERAND_WIDTH: width_q  <= width_code_t'(cfg_data);
				REG_SIGNED_MODE:   signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bda_ctrl #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.width_code (width_q),
		.status     (status),
		.busy       (busy),
		.op         (op),
		.emit       (emit),
		.emit_char  (emit_char),
		.emit_last  (emit_last)
	);

	bda_unit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_unit (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.value       (value),
		.width_code  (width_q),
		.signed_mode (signed_q),
		.status      (status)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

FILE: rtl/bda_unit.sv
// shift and add-3 datapath: operand load, double dabble step, digit shift-out
`timescale 1ns / 1ps

module bda_unit import bda_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bda_op_t             op,
	input  logic [VALUE_W-1:0]  value,
	input  width_code_t         width_code,
	input  logic                signed_mode,
	output bda_status_t         status
);

	localparam int BCD_W = 4 * MAX_DIGITS;

	logic [BCD_W-1:0]   bcd_q;
	logic [VALUE_W-1:0] bin_q;
	logic               neg_q;
	logic               ovf_q;

	logic [VALUE_W-1:0] mask;
	logic [VALUE_W-1:0] sign_sel;
	logic [VALUE_W-1:0] masked;
	logic [VALUE_W-1:0] magnitude;
	logic [VALUE_W-1:0] aligned;
	logic               negative;
	logic [BCD_W-1:0]   adj;

	// operand masking and sign handling
	always_comb begin
		unique case (width_code)
			WIDTH_8: begin
				mask     = 64'h0000_0000_0000_00FF;
				sign_sel = 64'h0000_0000_0000_0080;
			end
			WIDTH_16: begin
				mask     = 64'h0000_0000_0000_FFFF;
				sign_sel = 64'h0000_0000_0000_8000;
			end
			WIDTH_32: begin
				mask     = 64'h0000_0000_FFFF_FFFF;
				sign_sel = 64'h0000_0000_8000_0000;
			end
			default: begin
				mask     = 64'hFFFF_FFFF_FFFF_FFFF;
				sign_sel = 64'h8000_0000_0000_0000;
			end
		endcase
		masked    = value & mask;
		negative  = signed_mode && ((masked & sign_sel) != '0);
		magnitude = negative ? ((~masked + 64'd1) & mask) : masked;
	end

	// left-align the magnitude so the msb of the selected width leads
	always_comb begin
		unique case (width_code)
			WIDTH_8:  aligned = magnitude << 56;
			WIDTH_16: aligned = magnitude << 48;
			WIDTH_32: aligned = magnitude << 32;
			default:  aligned = magnitude;
		endcase
	end

	// add 3 to every bcd digit of 5 or more
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (op.load) begin
			neg_q <= negative;
			ovf_q <= 1'b0;
		end else if (op.dabble) begin
			ovf_q <= ovf_q | adj[BCD_W-1];
		end
	end

	// digit and operand shift registers
	always_ff @(posedge clk) begin
		if (op.load) begin
			bcd_q <= '0;
			bin_q <= aligned;
		end else if (op.dabble) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end else if (op.shift_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign status.top_digit = bcd_q[BCD_W-1 -: 4];
	assign status.overflow  = ovf_q;
	assign status.negative  = neg_q;

endmodule

FILE: rtl/bda_ctrl.sv
// sequencer: bit iterations, leading zero skip, sign and digit emission
`timescale 1ns / 1ps

module bda_ctrl import bda_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  width_code_t       width_code,
	input  bda_status_t       status,
	output logic              busy,
	output bda_op_t           op,
	output logic              emit,
	output logic [CHAR_W-1:0] emit_char,
	output logic              emit_last
);

	localparam int REM_W = $clog2(MAX_DIGITS + 1);
	localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);

	state_t               state_q, state_d;
	logic [BITCNT_W-1:0]  bits_q, bits_d;
	logic [REM_W-1:0]     rem_q, rem_d;
	logic [BITCNT_W-1:0]  bits_init;

	// number of iterations for the selected width
	always_comb begin
		unique case (width_code)
			WIDTH_8:  bits_init = BITCNT_W'(8);
			WIDTH_16: bits_init = BITCNT_W'(16);
			WIDTH_32: bits_init = BITCNT_W'(32);
			default:  bits_init = BITCNT_W'(64);
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q  <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			bits_q  <= bits_d;
			rem_q   <= rem_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d        = state_q;
		bits_d         = bits_q;
		rem_d          = rem_q;
		op             = '0;
		emit           = 1'b0;
		emit_char      = CHAR_ZERO + {2'b00, status.top_digit};
		emit_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op.load = 1'b1;
					bits_d  = bits_init;
					rem_d   = REM_FULL;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				op.dabble = 1'b1;
				bits_d    = bits_q - BITCNT_W'(1);
				if (bits_q == BITCNT_W'(1)) begin
					state_d = status.negative ? ST_SIGN : ST_SKIP;
				end
			end
			ST_SIGN: begin
				emit      = 1'b1;
				emit_char = CHAR_MINUS;
				state_d   = ST_SKIP;
			end
			ST_SKIP: begin
				// drop leading zeros, keeping the last digit, unless digits were lost off the top
				if (!status.overflow && status.top_digit == 4'd0
						&& rem_q > REM_W'(1)) begin
					op.shift_digit = 1'b1;
					rem_d          = rem_q - REM_W'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit           = 1'b1;
				emit_last      = (rem_q == REM_W'(1));
				op.shift_digit = 1'b1;
				rem_d          = rem_q - REM_W'(1);
				if (rem_q == REM_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// an accepted item starts the bit iterations
	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_CONV))
		else $error("accepted item did not start conversion");

	// the final character returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final character");

	// no digit is shifted out while bits are still entering
	a_conv_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (rem_q == REM_FULL && !op.shift_digit))
		else $error("digit count changed during conversion");

	// the digit count never runs out before the final character
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (rem_q != '0))
		else $error("digit count underflow");

endmodule

FILE: test/tb_binary_to_decimal_ascii.sv
// testbench for the binary to decimal ascii converter
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
	import bda_pkg::*;

	localparam int DIGITS        = MAX_DIGITS_DEF;
	localparam int PHASE_ITEMS   = 36;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int REPORT_CAP    = 40;
	// indexes past the register list, writes there must be dropped
	localparam logic [1:0] REG_UNUSED_A = 2'd2;
	localparam logic [1:0] REG_UNUSED_B = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               strobe;
	logic [CHAR_W-1:0]  character;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [1:0]         cfg_data;

	binary_to_decimal_ascii #(.MAX_DIGITS(DIGITS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// expected decimal text of every accepted operand, in order
	class decimal_text_board;
		typedef struct packed {
			logic [CHAR_W-1:0] ch;
			logic              fin;
		} text_char_t;

		text_char_t  pending_chars[$];
		width_code_t width_code;
		logic        is_signed;
		int          errors;

		function new();
			width_code = WIDTH_64;
			is_signed  = 1'b0;
			errors     = 0;
		endfunction

		static function logic [VALUE_W-1:0] width_mask(width_code_t code);
			case (code)
				WIDTH_8:  return 64'hFF;
				WIDTH_16: return 64'hFFFF;
				WIDTH_32: return 64'hFFFF_FFFF;
				default:  return '1;
			endcase
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction

		task report(string msg);
			if (errors < REPORT_CAP)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void write_reg(logic [1:0] idx, logic [1:0] data);
			if (idx == REG_OPERAND_WIDTH)
				width_code = width_code_t'(data);
			else if (idx == REG_SIGNED_MODE)
				is_signed = data[0];
		endfunction

		// split the magnitude into digits, least significant first
		function void note_operand(logic [VALUE_W-1:0] raw);
			logic [VALUE_W-1:0] mask;
			logic [VALUE_W-1:0] mag;
			logic [3:0]         digits[$];
			text_char_t         c;
			int                 k;
			mask = width_mask(width_code);
			mag  = raw & mask;
			if (is_signed && (mag & ~(mask >> 1)) != 0) begin
				c.ch  = CHAR_MINUS;
				c.fin = 1'b0;
				pending_chars.push_back(c);
				// the signed minimum wraps back onto its own unsigned magnitude
				mag = (~mag + 64'd1) & mask;
			end
			while (mag != 0 && digits.size() < DIGITS) begin
				digits.push_back(4'(mag % 64'd10));
				mag = mag / 64'd10;
			end
			if (digits.size() == 0)
				digits.push_back(4'd0);
			for (k = digits.size() - 1; k >= 0; k--) begin
				c.ch  = CHAR_ZERO + digits[k];
				c.fin = (k == 0);
				pending_chars.push_back(c);
			end
		endfunction

		task check_character(logic [CHAR_W-1:0] ch, logic fin);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected character %0d last %0d", ch, fin));
			end else begin
				want = pending_chars.pop_front();
				if (ch !== want.ch)
					report($sformatf("character %0d, want %0d", ch, want.ch));
				if (fin !== want.fin)
					report($sformatf("last %0d, want %0d", fin, want.fin));
			end
		endtask
	endclass

	decimal_text_board sb;
	int                idle_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// transfer monitor: operands, characters and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_character(character, last);
			if (start && !busy)
				sb.note_operand(value);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_MAX) begin
				$display("[binary_to_decimal_ascii] ERROR");
				$finish;
			end
		end
	end

	// operand stimulus biased toward sign, width and power of ten boundaries
	function automatic logic [VALUE_W-1:0] pick_operand(width_code_t code);
		logic [VALUE_W-1:0] mask;
		logic [VALUE_W-1:0] noise;
		logic [VALUE_W-1:0] x;
		logic [VALUE_W-1:0] p;
		mask  = decimal_text_board::width_mask(code);
		noise = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: x = noise;
			1: x = 64'($urandom_range(0, 20));
			2: x = (~(mask >> 1) & mask) + 64'($urandom_range(0, 3)) - 64'd2;
			3: x = mask - 64'($urandom_range(0, 3));
			4: begin
				p = 64'd1;
				repeat ($urandom_range(1, 19)) p = p * 64'd10;
				x = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: x = noise >> $urandom_range(0, 63);
		endcase
		// bits above the selected width carry noise
		return (noise & ~mask) | (x & mask);
	endfunction

	task automatic send(input logic [VALUE_W-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		start <= 1'b0;
		value <= {$urandom, $urandom};
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off until every expected character is out and the block is idle
	task automatic drain();
		pause_sender(1);
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_index <= 2'($urandom);
		cfg_data  <= 2'($urandom);
	endtask

	initial begin
		int         ph;
		int         sent;
		int         burst;
		logic       pressed;
		logic [1:0] mode;
		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		value       = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: 64-bit unsigned
		send('0);
		send('1);
		send(64'd1);
		send(64'd10000000000000000000);
		send(64'd9);
		drain();

		// 64-bit signed: minimum, minus one, maximum, minus ten
		write_reg(REG_SIGNED_MODE, 2'b01);
		send(64'h8000_0000_0000_0000);
		send('1);
		send(64'h7FFF_FFFF_FFFF_FFFF);
		send(64'hFFFF_FFFF_FFFF_FFF6);
		drain();

		// 8-bit signed with noise above the width
		write_reg(REG_OPERAND_WIDTH, WIDTH_8);
		send(64'hABCD_EF01_2345_6780);
		send(64'h7F);
		send('1);
		send(64'h1234_5600);
		drain();

		// writes past the register list are dropped, only bit 0 sets the mode
		write_reg(REG_UNUSED_A, 2'b11);
		write_reg(REG_UNUSED_B, 2'b01);
		write_reg(REG_SIGNED_MODE, 2'b10);
		send(64'hFF);
		send(64'hFFFF_FFFF_FFFF_FF00);
		drain();

		// 16-bit and 32-bit sign boundaries
		write_reg(REG_OPERAND_WIDTH, WIDTH_16);
		write_reg(REG_SIGNED_MODE, 2'b11);
		send(64'h8000);
		send(64'h7FFF);
		drain();
		write_reg(REG_OPERAND_WIDTH, WIDTH_32);
		send(64'hFFFF_FFFF_8000_0000);
		drain();
		write_reg(REG_SIGNED_MODE, 2'b00);
		send(64'hFFFF_FFFF);
		drain();

		// random bursts over every width and sign setting
		for (ph = 0; ph < 8; ph++) begin
			drain();
			mode    = 2'($urandom);
			mode[0] = (ph >= 4);
			if ($urandom_range(0, 2) == 0)
				write_reg(2'($urandom_range(2, 3)), 2'($urandom));
			write_reg(REG_OPERAND_WIDTH, 2'(ph));
			write_reg(REG_SIGNED_MODE, mode);
			sent    = 0;
			pressed = 1'b0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					if (sent < PHASE_ITEMS) begin
						send(pick_operand(sb.width_code));
						sent++;
					end
				end
				// once per phase the sender waits for all text to come out
				if (!pressed && sent >= PHASE_ITEMS / 2) begin
					drain();
					pressed = 1'b1;
				end else if ($urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 2) == 0)
						pause_sender($urandom_range(40, 100));
					else
						pause_sender($urandom_range(1, 12));
				end
			end
		end

		drain();
		repeat (DIGITS + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("[binary_to_decimal_ascii] OK");
		else
			$display("[binary_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule
